### rtl/core/lprx_pkg.sv
`default_nettype none

package lprx_pkg;

  // ring geometry
  localparam int unsigned MAX_RING_BYTES = 65536;
  localparam int unsigned HDR_BYTES      = 4;

  localparam logic [16:0] RESET_BUFFER_BYTES = 17'(MAX_RING_BYTES);
  localparam logic [17:0] HDR_18             = 18'(HDR_BYTES);

  // register indexes on the config port (address bit 2)
  localparam logic [0:0] REG_BUFFER_BYTES = 1'b0;
  localparam logic [0:0] REG_OWNER_HANDLE = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_CONSUME  = 2'd2,
    OP_INVALID  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_HEADER     = 3'd0,
    KIND_GRANT      = 3'd1,
    KIND_OVERFLOW   = 3'd2,
    KIND_BAD_HANDLE = 3'd3,
    KIND_DONE       = 3'd4,
    KIND_RECORD     = 3'd5,
    KIND_REREAD     = 3'd6,
    KIND_BAD_OP     = 3'd7
  } kind_t;

  // live configuration seen by the sequencer
  typedef struct packed {
    logic [16:0] ring_size;
    logic [15:0] owner_handle;
  } cfg_t;

  // shared add / subtract unit
  typedef struct packed {
    logic [17:0] a;
    logic [17:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [17:0] result;
    logic        neg;
    logic [17:0] floor_result;
  } alu_rsp_t;

  // round a length up to a whole number of header words
  function automatic logic [16:0] pad_up(input logic [15:0] n);
    logic [16:0] sum;
    sum = {1'b0, n} + 17'(HDR_BYTES - 1);
    return sum & ~17'(HDR_BYTES - 1);
  endfunction

endpackage

`default_nettype wire

### rtl/core/length_prefixed_rx_ring_manager.sv
`default_nettype none

// channel   direction  handshake            payload
// in        to block   in_valid/in_ready    op, req_handle, length
// out       from block out_valid/out_ready  kind, address, value, overflows, fill, last
// cfg       to block   APB psel/penable     paddr, pwdata, prdata (pready tied high)
//
// one item at a time; a single shared 18-bit add/subtract unit steps through it:
// allocate checks the free room, may emit a wrap marker, then a header and the grant;
// complete commits the record; consume frees a record or a wrap marker; others just reply.
// results sit in an output register; a stalled output holds the sequencer at its
// next emit. synchronous reset clears pointers, counts and the output valid.

module length_prefixed_rx_ring_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] req_handle,
  input  logic [15:0] length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [15:0] address,
  output logic [15:0] value,
  output logic [15:0] overflows,
  output logic [16:0] fill,
  output logic        last
);
  import lprx_pkg::*;

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  lprx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lprx_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  lprx_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .req_handle (req_handle),
    .length     (length),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .address    (address),
    .value      (value),
    .overflows  (overflows),
    .fill       (fill),
    .last       (last),
    .alu_req    (alu_req),
    .alu_rsp    (alu_rsp)
  );

endmodule

`default_nettype wire

### rtl/core/lprx_alu.sv
`default_nettype none

module lprx_alu (
  input  lprx_pkg::alu_req_t req,
  output lprx_pkg::alu_rsp_t rsp
);
  import lprx_pkg::*;

  logic [18:0] full;
  logic [17:0] b_in;

  // a + b, or a - b as a + ~b + 1; carry out clear means a borrow
  always_comb begin
    b_in = req.sub ? ~req.b : req.b;
    full = {1'b0, req.a} + {1'b0, b_in} + {18'd0, req.sub};
    rsp.result       = full[17:0];
    rsp.neg          = req.sub & ~full[18];
    rsp.floor_result = rsp.neg ? 18'd0 : full[17:0];
  end

endmodule

`default_nettype wire

### rtl/core/lprx_cfg.sv
`default_nettype none

module lprx_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lprx_pkg::cfg_t    cfg
);
  import lprx_pkg::*;

  logic [16:0] buffer_bytes;
  logic [15:0] owner_handle;
  logic [16:0] capped;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes <= RESET_BUFFER_BYTES;
      owner_handle <= 16'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_BUFFER_BYTES: buffer_bytes <= pwdata[16:0];
        REG_OWNER_HANDLE: owner_handle <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_BUFFER_BYTES: prdata = {15'd0, buffer_bytes};
      REG_OWNER_HANDLE: prdata = {16'd0, owner_handle};
      default:          prdata = 32'd0;
    endcase
  end

  // usable ring size: capped, then whole header words only
  always_comb begin
    capped = (buffer_bytes > 17'(MAX_RING_BYTES)) ? 17'(MAX_RING_BYTES) : buffer_bytes;
    cfg.ring_size    = capped & ~17'(HDR_BYTES - 1);
    cfg.owner_handle = owner_handle;
  end

endmodule

`default_nettype wire

### rtl/core/lprx_seq.sv
`default_nettype none

module lprx_seq (
  input  logic                clk,
  input  logic                rst,
  input  lprx_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [15:0]         req_handle,
  input  logic [15:0]         length,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          kind,
  output logic [15:0]         address,
  output logic [15:0]         value,
  output logic [15:0]         overflows,
  output logic [16:0]         fill,
  output logic                last,
  output lprx_pkg::alu_req_t  alu_req,
  input  lprx_pkg::alu_rsp_t  alu_rsp
);
  import lprx_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE    = 22'h000001,
    S_ROOM    = 22'h000002,
    S_FIT     = 22'h000004,
    S_ENDSUM  = 22'h000008,
    S_ENDCHK  = 22'h000010,
    S_MARK    = 22'h000020,
    S_ADEF    = 22'h000040,
    S_HDR     = 22'h000080,
    S_REPLY   = 22'h000100,
    S_CSUM    = 22'h000200,
    S_CCOMMIT = 22'h000400,
    S_CEND    = 22'h000800,
    S_CCHK    = 22'h001000,
    S_CTAIL   = 22'h002000,
    S_CADD    = 22'h004000,
    S_FTAIL   = 22'h008000,
    S_FSUB    = 22'h010000,
    S_RNEXT   = 22'h020000,
    S_RCHK    = 22'h040000,
    S_RTAIL   = 22'h080000,
    S_RADJ    = 22'h100000,
    S_RFREE   = 22'h200000
  } state_t;

  state_t      state, state_next;

  // ring pointers and counts
  logic [15:0] write_offset, write_offset_next;
  logic [15:0] read_offset, read_offset_next;
  logic [16:0] committed_fill, committed_fill_next;
  logic [16:0] deferred_fill, deferred_fill_next;
  logic [15:0] pending_length, pending_length_next;
  logic [15:0] overflow_total, overflow_total_next;

  // working registers
  logic [15:0] len_q, len_q_next;
  logic [17:0] acc, acc_next;
  logic [17:0] aux, aux_next;
  kind_t       rkind, rkind_next;
  logic [15:0] raddr, raddr_next;
  logic [15:0] rval, rval_next;

  // output register
  logic        out_valid_next;
  logic [2:0]  kind_next;
  logic [15:0] address_next, value_next, overflows_next;
  logic [16:0] fill_next;
  logic        last_next;

  logic [17:0] size18;
  logic [17:0] len4;
  logic [16:0] blen;
  logic [17:0] acc4;
  logic        out_free;
  logic        handle_ok;

  assign size18    = {1'b0, cfg.ring_size};
  assign len4      = {2'd0, len_q} + HDR_18;
  assign blen      = pad_up(pending_length);
  assign acc4      = acc + HDR_18;
  assign out_free  = !out_valid || out_ready;
  assign handle_ok = (req_handle == cfg.owner_handle);
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next          = state;
    write_offset_next   = write_offset;
    read_offset_next    = read_offset;
    committed_fill_next = committed_fill;
    deferred_fill_next  = deferred_fill;
    pending_length_next = pending_length;
    overflow_total_next = overflow_total;
    len_q_next          = len_q;
    acc_next            = acc;
    aux_next            = aux;
    rkind_next          = rkind;
    raddr_next          = raddr;
    rval_next           = rval;
    alu_req.a           = 18'd0;
    alu_req.b           = 18'd0;
    alu_req.sub         = 1'b0;

    // output register drains when taken
    out_valid_next = out_valid && !out_ready;
    kind_next      = kind;
    address_next   = address;
    value_next     = value;
    overflows_next = overflows;
    fill_next      = fill;
    last_next      = last;

    case (state)
      // decode a new item
      S_IDLE: begin
        if (in_valid) begin
          len_q_next = length;
          raddr_next = 16'd0;
          rval_next  = 16'd0;
          case (op_t'(op))
            OP_ALLOC: begin
              if (!handle_ok) begin
                rkind_next = KIND_BAD_HANDLE;
                state_next = S_REPLY;
              end else begin
                state_next = S_ROOM;
              end
            end
            OP_COMPLETE: begin
              if (!handle_ok) begin
                rkind_next = KIND_BAD_HANDLE;
                state_next = S_REPLY;
              end else begin
                state_next = S_CSUM;
              end
            end
            OP_CONSUME: begin
              if (committed_fill == 17'd0) begin
                rkind_next = KIND_REREAD;
                raddr_next = read_offset;
                state_next = S_REPLY;
              end else if (length == 16'd0 && read_offset != 16'd0) begin
                state_next = S_FTAIL;
              end else begin
                rkind_next = KIND_RECORD;
                raddr_next = read_offset + 16'(HDR_BYTES);
                rval_next  = length;
                aux_next   = HDR_18 + {1'b0, pad_up(length)};
                state_next = S_RNEXT;
              end
            end
            default: begin
              rkind_next = KIND_BAD_OP;
              state_next = S_REPLY;
            end
          endcase
        end
      end

      // allocate: free room, floored at zero
      S_ROOM: begin
        alu_req.a   = size18;
        alu_req.b   = {1'b0, committed_fill};
        alu_req.sub = 1'b1;
        acc_next    = alu_rsp.floor_result;
        state_next  = S_FIT;
      end

      // allocate: record plus header against free room
      S_FIT: begin
        alu_req.a   = acc;
        alu_req.b   = len4;
        alu_req.sub = 1'b1;
        if (alu_rsp.neg) begin
          overflow_total_next = overflow_total + 16'd1;
          rkind_next          = KIND_OVERFLOW;
          rval_next           = len_q;
          state_next          = S_REPLY;
        end else begin
          state_next = S_ENDSUM;
        end
      end

      // allocate: end of header and data
      S_ENDSUM: begin
        alu_req.a  = {2'd0, write_offset};
        alu_req.b  = len4;
        acc_next   = alu_rsp.result;
        state_next = S_ENDCHK;
      end

      // allocate: past the end of the ring means a wrap marker first
      S_ENDCHK: begin
        alu_req.a   = size18;
        alu_req.b   = acc;
        alu_req.sub = 1'b1;
        state_next  = alu_rsp.neg ? S_MARK : S_HDR;
      end

      // allocate: emit wrap marker and size the skipped tail
      S_MARK: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          kind_next      = KIND_HEADER;
          address_next   = write_offset;
          value_next     = 16'd0;
          overflows_next = overflow_total;
          fill_next      = committed_fill;
          last_next      = 1'b0;
          alu_req.a      = size18;
          alu_req.b      = {2'd0, write_offset};
          alu_req.sub    = 1'b1;
          acc_next       = alu_rsp.floor_result;
          state_next     = S_ADEF;
        end
      end

      // allocate: tail goes into deferred fill, restart at zero
      S_ADEF: begin
        alu_req.a          = {1'b0, deferred_fill};
        alu_req.b          = acc;
        deferred_fill_next = alu_rsp.result[16:0];
        write_offset_next  = 16'd0;
        state_next         = S_HDR;
      end

      // allocate: emit header, account its bytes, set up the grant
      S_HDR: begin
        if (out_free) begin
          out_valid_next      = 1'b1;
          kind_next           = KIND_HEADER;
          address_next        = write_offset;
          value_next          = len_q;
          overflows_next      = overflow_total;
          fill_next           = committed_fill;
          last_next           = 1'b0;
          alu_req.a           = {1'b0, deferred_fill};
          alu_req.b           = HDR_18;
          deferred_fill_next  = alu_rsp.result[16:0];
          write_offset_next   = write_offset + 16'(HDR_BYTES);
          pending_length_next = len_q;
          rkind_next          = KIND_GRANT;
          raddr_next          = write_offset + 16'(HDR_BYTES);
          rval_next           = len_q;
          state_next          = S_REPLY;
        end
      end

      // final item of the request
      S_REPLY: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          kind_next      = rkind;
          address_next   = raddr;
          value_next     = rval;
          overflows_next = overflow_total;
          fill_next      = committed_fill;
          last_next      = 1'b1;
          state_next     = S_IDLE;
        end
      end

      // complete: committed plus deferred
      S_CSUM: begin
        alu_req.a  = {1'b0, committed_fill};
        alu_req.b  = {1'b0, deferred_fill};
        acc_next   = {1'b0, alu_rsp.result[16:0]};
        state_next = S_CCOMMIT;
      end

      // complete: add padded data and commit
      S_CCOMMIT: begin
        alu_req.a           = acc;
        alu_req.b           = {1'b0, blen};
        committed_fill_next = alu_rsp.result[16:0];
        deferred_fill_next  = 17'd0;
        state_next          = S_CEND;
      end

      // complete: end of the record
      S_CEND: begin
        alu_req.a  = {2'd0, write_offset};
        alu_req.b  = {1'b0, blen};
        acc_next   = alu_rsp.result;
        state_next = S_CCHK;
      end

      // complete: room for another header after the record?
      S_CCHK: begin
        alu_req.a   = size18;
        alu_req.b   = acc4;
        alu_req.sub = 1'b1;
        if (alu_rsp.neg) begin
          state_next = S_CTAIL;
        end else begin
          write_offset_next = acc[15:0];
          rkind_next        = KIND_DONE;
          raddr_next        = acc[15:0];
          rval_next         = pending_length;
          state_next        = S_REPLY;
        end
      end

      // complete: size the unusable tail
      S_CTAIL: begin
        alu_req.a   = size18;
        alu_req.b   = acc;
        alu_req.sub = 1'b1;
        acc_next    = alu_rsp.floor_result;
        state_next  = S_CADD;
      end

      // complete: commit the tail and wrap
      S_CADD: begin
        alu_req.a           = {1'b0, committed_fill};
        alu_req.b           = acc;
        committed_fill_next = alu_rsp.result[16:0];
        write_offset_next   = 16'd0;
        rkind_next          = KIND_DONE;
        raddr_next          = 16'd0;
        rval_next           = pending_length;
        state_next          = S_REPLY;
      end

      // consume wrap marker: size the tail
      S_FTAIL: begin
        alu_req.a   = size18;
        alu_req.b   = {2'd0, read_offset};
        alu_req.sub = 1'b1;
        acc_next    = alu_rsp.floor_result;
        state_next  = S_FSUB;
      end

      // consume wrap marker: free the tail, ask for a reread at zero
      S_FSUB: begin
        alu_req.a           = {1'b0, committed_fill};
        alu_req.b           = acc;
        alu_req.sub         = 1'b1;
        committed_fill_next = alu_rsp.floor_result[16:0];
        read_offset_next    = 16'd0;
        rkind_next          = KIND_REREAD;
        raddr_next          = 16'd0;
        rval_next           = 16'd0;
        state_next          = S_REPLY;
      end

      // consume record: next read offset
      S_RNEXT: begin
        alu_req.a  = {2'd0, read_offset};
        alu_req.b  = aux;
        acc_next   = alu_rsp.result;
        state_next = S_RCHK;
      end

      // consume record: room for another header after it?
      S_RCHK: begin
        alu_req.a   = size18;
        alu_req.b   = acc4;
        alu_req.sub = 1'b1;
        if (alu_rsp.neg) begin
          state_next = S_RTAIL;
        end else begin
          read_offset_next = acc[15:0];
          state_next       = S_RFREE;
        end
      end

      // consume record: size the tail
      S_RTAIL: begin
        alu_req.a        = size18;
        alu_req.b        = acc;
        alu_req.sub      = 1'b1;
        acc_next         = alu_rsp.floor_result;
        read_offset_next = 16'd0;
        state_next       = S_RADJ;
      end

      // consume record: tail joins the freed bytes
      S_RADJ: begin
        alu_req.a  = aux;
        alu_req.b  = acc;
        aux_next   = alu_rsp.result;
        state_next = S_RFREE;
      end

      // consume record: release the bytes
      S_RFREE: begin
        alu_req.a           = {1'b0, committed_fill};
        alu_req.b           = aux;
        alu_req.sub         = 1'b1;
        committed_fill_next = alu_rsp.floor_result[16:0];
        state_next          = S_REPLY;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control and pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      write_offset   <= 16'd0;
      read_offset    <= 16'd0;
      committed_fill <= 17'd0;
      deferred_fill  <= 17'd0;
      pending_length <= 16'd0;
      overflow_total <= 16'd0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      write_offset   <= write_offset_next;
      read_offset    <= read_offset_next;
      committed_fill <= committed_fill_next;
      deferred_fill  <= deferred_fill_next;
      pending_length <= pending_length_next;
      overflow_total <= overflow_total_next;
      out_valid      <= out_valid_next;
    end
  end

  // working and output payload
  always_ff @(posedge clk) begin
    len_q     <= len_q_next;
    acc       <= acc_next;
    aux       <= aux_next;
    rkind     <= rkind_next;
    raddr     <= raddr_next;
    rval      <= rval_next;
    kind      <= kind_next;
    address   <= address_next;
    value     <= value_next;
    overflows <= overflows_next;
    fill      <= fill_next;
    last      <= last_next;
  end

endmodule

`default_nettype wire
